// File: design/dfa_match_span_scanner_unit_assert.svh
// Assertion macros for the DFA span scanner. The assertions sample on aclk
// and are switched off while aresetn is low.
`ifndef DFA_MATCH_SPAN_SCANNER_UNIT_ASSERT_SVH
`define DFA_MATCH_SPAN_SCANNER_UNIT_ASSERT_SVH

`ifndef SYNTH

`define DMS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dms check failed");

`define DMS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dms check failed");

`else

`define DMS_ASSERT_IMP(label, ante, cons)

`define DMS_ASSERT_NXT(label, ante, cons)

`endif

`endif

// File: design/dms_pkg.sv
package dms_pkg;

    localparam int NUM_STATES    = 64;
    localparam int ALPHABET_BASE = 32;
    localparam int POSITION_BITS = 16;
    localparam int SYMBOL_LIMIT  = 128;
    localparam int COLUMNS       = SYMBOL_LIMIT - ALPHABET_BASE;

    localparam int STATE_BITS    = $clog2(NUM_STATES);
    localparam int COL_BITS      = $clog2(COLUMNS);
    localparam int TBL_DEPTH     = NUM_STATES * COLUMNS;
    localparam int TBL_ADDR_BITS = $clog2(TBL_DEPTH);

    // Port field widths
    localparam int OP_BITS       = 2;
    localparam int IDX_BITS      = 6;
    localparam int SYM_BITS      = 7;
    localparam int OUT_POS_BITS  = 16;

    // Configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MATCH_MODE  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_STATE = 1'd1;

    localparam logic MODE_FIND_ALL   = 1'b0;
    localparam logic MODE_FULL_MATCH = 1'b1;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_LOAD_TRANS = 2'd0;
    localparam logic [OP_BITS-1:0] OP_LOAD_MARKS = 2'd1;
    localparam logic [OP_BITS-1:0] OP_SCAN       = 2'd2;

    // Result kinds
    localparam logic KIND_SPAN    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // State mark word: accepting in the upper bit, dead in the lower
    localparam int MARK_BITS     = 2;
    localparam int MARK_ACC_BIT  = 1;
    localparam int MARK_DEAD_BIT = 0;

    // Result queue
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic                    kind;
        logic [OUT_POS_BITS-1:0] first;
        logic [OUT_POS_BITS-1:0] final_pos;
        logic                    accepted;
        logic                    last;
    } result_t;

    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t entry0;
        result_t entry1;
    } push_t;

    typedef struct packed {
        logic                     we;
        logic [TBL_ADDR_BITS-1:0] waddr;
        logic [STATE_BITS-1:0]    wdata;
        logic                     re;
        logic [TBL_ADDR_BITS-1:0] raddr;
    } tbl_port_t;

    typedef struct packed {
        logic                  we;
        logic [STATE_BITS-1:0] waddr;
        logic [MARK_BITS-1:0]  wdata;
        logic                  re;
        logic [STATE_BITS-1:0] raddr;
    } mark_port_t;

    function automatic logic [STATE_BITS-1:0] state_num(input logic [IDX_BITS-1:0] v);
        return STATE_BITS'(v % NUM_STATES);
    endfunction

    function automatic logic [COL_BITS-1:0] col_of(input logic [SYM_BITS-1:0] s);
        if (s >= SYM_BITS'(ALPHABET_BASE)) begin
            return COL_BITS'(s - SYM_BITS'(ALPHABET_BASE));
        end
        return '0;
    endfunction

    function automatic logic [TBL_ADDR_BITS-1:0] tbl_index(input logic [STATE_BITS-1:0] st,
                                                           input logic [COL_BITS-1:0]   col);
        return TBL_ADDR_BITS'(TBL_ADDR_BITS'(st) * TBL_ADDR_BITS'(COLUMNS))
               + TBL_ADDR_BITS'(col);
    endfunction

endpackage

// File: design/dfa_match_span_scanner_unit.sv
// DFA span scanner. Load requests (operation 0 and 1) write one transition or
// one state's marks. A scan request reads the transition table (6144 x 6, one
// entry per state and printable column) and, in the cycle after, the mark
// memory (64 x 2) at the new state, then decides; the next request is taken
// in the decide cycle unless a rescan follows or the queue lacks room.
// A dead state hit with a span open closes the span and rescans the same
// symbol from the start state. Both memories have a registered read; these
// two reads in series set the rate. Results (at most two per request) leave
// through a 4-entry queue, so the scanner carries on while results wait. The
// memories come up undefined; every entry must be loaded before a scan reads
// it. The user must write configuration (match mode, start state) only while
// no request is in flight; the block itself does not enforce this. Writing
// the start state also restarts the current state.
module dfa_match_span_scanner_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [dms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dms_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // request channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [dms_pkg::OP_BITS-1:0]        s_operation,
    input  logic [dms_pkg::IDX_BITS-1:0]       s_state_index,
    input  logic [dms_pkg::SYM_BITS-1:0]       s_symbol,
    input  logic [dms_pkg::IDX_BITS-1:0]       s_next_state,
    input  logic                               s_is_accepting,
    input  logic                               s_is_dead,
    input  logic                               s_end_of_text,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_result_kind,
    output logic [dms_pkg::OUT_POS_BITS-1:0]   m_match_start,
    output logic [dms_pkg::OUT_POS_BITS-1:0]   m_match_end,
    output logic                               m_accepted,
    output logic                               m_last
);

    dms_pkg::tbl_port_t                tbl_port;
    dms_pkg::mark_port_t               mark_port;
    dms_pkg::push_t                    push;
    dms_pkg::result_t                  head;
    logic [dms_pkg::STATE_BITS-1:0]    tbl_rdata;
    logic [dms_pkg::MARK_BITS-1:0]     mark_rdata;
    logic [dms_pkg::FIFO_CNT_BITS-1:0] fifo_count;

    // sequencing, span tracking and memory addressing
    dms_scan_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_state_index  (s_state_index),
        .s_symbol       (s_symbol),
        .s_next_state   (s_next_state),
        .s_is_accepting (s_is_accepting),
        .s_is_dead      (s_is_dead),
        .s_end_of_text  (s_end_of_text),
        .tbl_port       (tbl_port),
        .tbl_rdata      (tbl_rdata),
        .mark_port      (mark_port),
        .mark_rdata     (mark_rdata),
        .fifo_count     (fifo_count),
        .push           (push)
    );

    // transition table: row per state, column per printable symbol
    dms_ram #(
        .WIDTH (dms_pkg::STATE_BITS),
        .DEPTH (dms_pkg::TBL_DEPTH)
    ) u_tbl_ram (
        .aclk  (aclk),
        .we    (tbl_port.we),
        .waddr (tbl_port.waddr),
        .wdata (tbl_port.wdata),
        .re    (tbl_port.re),
        .raddr (tbl_port.raddr),
        .rdata (tbl_rdata)
    );

    // accepting and dead marks per state
    dms_ram #(
        .WIDTH (dms_pkg::MARK_BITS),
        .DEPTH (dms_pkg::NUM_STATES)
    ) u_mark_ram (
        .aclk  (aclk),
        .we    (mark_port.we),
        .waddr (mark_port.waddr),
        .wdata (mark_port.wdata),
        .re    (mark_port.re),
        .raddr (mark_port.raddr),
        .rdata (mark_rdata)
    );

    // result queue decouples the scanner from a stalled consumer
    dms_result_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .count   (fifo_count),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_result_kind = head.kind;
    assign m_match_start = head.first;
    assign m_match_end   = head.final_pos;
    assign m_accepted    = head.accepted;
    assign m_last        = head.last;

endmodule

// File: design/dms_ram.sv
module dms_ram #(
    parameter int  WIDTH     = 8,
    parameter int  DEPTH     = 64,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read data is registered and held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/dms_result_fifo.sv
module dms_result_fifo (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dms_pkg::push_t                    push,
    output logic [dms_pkg::FIFO_CNT_BITS-1:0] count,
    output logic                              m_valid,
    input  logic                              m_ready,
    output dms_pkg::result_t                  head
);

    localparam int PTR_BITS = dms_pkg::FIFO_PTR_BITS;
    localparam int CNT_BITS = dms_pkg::FIFO_CNT_BITS;

    dms_pkg::result_t entry_mem [dms_pkg::FIFO_DEPTH];

    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [CNT_BITS-1:0] n_push;
    logic [CNT_BITS:0]   count_sum;
    logic                pop;

    assign pop       = m_valid && m_ready;
    assign n_push    = CNT_BITS'(push.valid0) + CNT_BITS'(push.valid1);
    assign count_sum = (CNT_BITS+1)'(count_reg) + (CNT_BITS+1)'(n_push);

    assign count_next  = CNT_BITS'(count_reg + n_push - CNT_BITS'(pop));
    assign wr_ptr_next = PTR_BITS'(wr_ptr_reg + PTR_BITS'(n_push));
    assign rd_ptr_next = PTR_BITS'(rd_ptr_reg + PTR_BITS'(pop));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // up to two entries land per cycle, always packed from entry0
    always_ff @(posedge aclk) begin
        if (push.valid0) begin
            entry_mem[wr_ptr_reg] <= push.entry0;
        end
        if (push.valid1) begin
            entry_mem[PTR_BITS'(wr_ptr_reg + PTR_BITS'(1))] <= push.entry1;
        end
    end

    assign m_valid = (count_reg != '0);
    assign head    = entry_mem[rd_ptr_reg];
    assign count   = count_reg;

`include "dfa_match_span_scanner_unit_assert.svh"

    `DMS_ASSERT_IMP(a_push_packed, push.valid1, push.valid0)
    `DMS_ASSERT_IMP(a_no_overflow, push.valid0, count_sum <= (CNT_BITS+1)'(dms_pkg::FIFO_DEPTH))
    `DMS_ASSERT_NXT(a_hold_count, m_valid && !m_ready && !push.valid0, count_reg == $past(count_reg))

endmodule

// File: design/dms_scan_ctrl.sv
module dms_scan_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [dms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dms_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [dms_pkg::OP_BITS-1:0]        s_operation,
    input  logic [dms_pkg::IDX_BITS-1:0]       s_state_index,
    input  logic [dms_pkg::SYM_BITS-1:0]       s_symbol,
    input  logic [dms_pkg::IDX_BITS-1:0]       s_next_state,
    input  logic                               s_is_accepting,
    input  logic                               s_is_dead,
    input  logic                               s_end_of_text,
    output dms_pkg::tbl_port_t                 tbl_port,
    input  logic [dms_pkg::STATE_BITS-1:0]     tbl_rdata,
    output dms_pkg::mark_port_t                mark_port,
    input  logic [dms_pkg::MARK_BITS-1:0]      mark_rdata,
    input  logic [dms_pkg::FIFO_CNT_BITS-1:0]  fifo_count,
    output dms_pkg::push_t                     push
);

    localparam int SB = dms_pkg::STATE_BITS;
    localparam int PB = dms_pkg::POSITION_BITS;
    localparam int OB = dms_pkg::OUT_POS_BITS;
    localparam int CB = dms_pkg::FIFO_CNT_BITS;

    // phase of the item in flight
    localparam logic [1:0] PH_IDLE = 2'd0;   // nothing in flight
    localparam logic [1:0] PH_TBL  = 2'd1;   // table data arriving
    localparam logic [1:0] PH_MRK  = 2'd2;   // marks arriving, decide

    logic [1:0]                 phase_reg, phase_next;
    logic                       mode_reg;
    logic [SB-1:0]              start_state_reg;
    logic [SB-1:0]              cur_reg, cur_next;
    logic [SB-1:0]              ns_reg;
    logic [dms_pkg::COL_BITS-1:0] col_reg;
    logic                       eot_reg;
    logic                       span_open_reg, span_open_next;
    logic [PB-1:0]              span_first_reg, span_first_next;
    logic [PB-1:0]              span_last_reg, span_last_next;
    logic [PB-1:0]              pos_reg, pos_next;
    logic                       pend_valid_reg, pend_valid_next;
    dms_pkg::result_t           pend_reg, pend_next;

    logic                       acc, dead;
    logic [SB-1:0]              cur_d, cur_fin, cur_issue;
    logic                       open_d;
    logic [PB-1:0]              first_d, last_d;
    logic                       rescan, finishing, flush;
    dms_pkg::result_t           e_pend, e_flush;
    logic [CB:0]                room_sum;
    logic                       room, accept, scan_acc;
    logic [dms_pkg::COL_BITS-1:0] col_in;

    assign acc    = mark_rdata[dms_pkg::MARK_ACC_BIT];
    assign dead   = mark_rdata[dms_pkg::MARK_DEAD_BIT];
    assign col_in = dms_pkg::col_of(s_symbol);

    // decision once the marks of the new state are in
    always_comb begin
        cur_d   = ns_reg;
        open_d  = span_open_reg;
        first_d = span_first_reg;
        last_d  = span_last_reg;
        rescan  = 1'b0;
        pend_next = pend_reg;
        if (phase_reg == PH_MRK && mode_reg == dms_pkg::MODE_FIND_ALL) begin
            if (acc) begin
                open_d = 1'b1;
                last_d = pos_reg;
            end else if (dead) begin
                cur_d = start_state_reg;
                if (span_open_reg) begin
                    pend_next.kind      = dms_pkg::KIND_SPAN;
                    pend_next.first     = OB'(span_first_reg);
                    pend_next.final_pos = OB'(span_last_reg);
                    pend_next.accepted  = 1'b0;
                    pend_next.last      = 1'b0;
                    open_d  = 1'b0;
                    first_d = pos_reg;
                    rescan  = 1'b1;
                end else begin
                    first_d = PB'(pos_reg + PB'(1));
                end
            end
        end
    end

    assign finishing = (phase_reg == PH_MRK) && !rescan;
    assign flush     = finishing && eot_reg
                       && ((mode_reg == dms_pkg::MODE_FULL_MATCH) || open_d);
    assign cur_fin   = eot_reg ? start_state_reg : cur_d;
    assign cur_issue = (phase_reg == PH_MRK) ? cur_fin : cur_reg;

    always_comb begin
        e_pend      = pend_reg;
        e_pend.last = !flush;
        if (mode_reg == dms_pkg::MODE_FULL_MATCH) begin
            e_flush.kind      = dms_pkg::KIND_VERDICT;
            e_flush.first     = '0;
            e_flush.final_pos = '0;
            e_flush.accepted  = acc;
        end else begin
            e_flush.kind      = dms_pkg::KIND_SPAN;
            e_flush.first     = OB'(first_d);
            e_flush.final_pos = OB'(last_d);
            e_flush.accepted  = 1'b0;
        end
        e_flush.last = 1'b1;
    end

    // results go out in order: the span closed by a dead state, then the flush
    always_comb begin
        push.entry0 = e_flush;
        push.entry1 = e_flush;
        push.valid0 = flush;
        push.valid1 = 1'b0;
        if (finishing && pend_valid_reg) begin
            push.entry0 = e_pend;
            push.valid0 = 1'b1;
            push.valid1 = flush;
        end
    end

    // room for this cycle's pushes and both results of one more item
    assign room_sum = (CB+1)'(fifo_count) + (CB+1)'(push.valid0) + (CB+1)'(push.valid1);
    assign room     = room_sum <= (CB+1)'(dms_pkg::FIFO_DEPTH - 2);
    assign s_ready  = room && ((phase_reg == PH_IDLE) || finishing);
    assign accept   = s_valid && s_ready;
    assign scan_acc = accept && (s_operation == dms_pkg::OP_SCAN);

    always_comb begin
        tbl_port.we    = accept && (s_operation == dms_pkg::OP_LOAD_TRANS)
                         && (s_symbol >= dms_pkg::SYM_BITS'(dms_pkg::ALPHABET_BASE));
        tbl_port.waddr = dms_pkg::tbl_index(dms_pkg::state_num(s_state_index), col_in);
        tbl_port.wdata = dms_pkg::state_num(s_next_state);
        tbl_port.re    = scan_acc || rescan;
        tbl_port.raddr = rescan ? dms_pkg::tbl_index(start_state_reg, col_reg)
                                : dms_pkg::tbl_index(cur_issue, col_in);
    end

    always_comb begin
        mark_port.we    = accept && (s_operation == dms_pkg::OP_LOAD_MARKS);
        mark_port.waddr = dms_pkg::state_num(s_state_index);
        mark_port.wdata = {s_is_accepting, s_is_dead};
        mark_port.re    = (phase_reg == PH_TBL);
        mark_port.raddr = tbl_rdata;
    end

    always_comb begin
        phase_next      = PH_IDLE;
        cur_next        = cur_reg;
        span_open_next  = span_open_reg;
        span_first_next = span_first_reg;
        span_last_next  = span_last_reg;
        pos_next        = pos_reg;
        pend_valid_next = pend_valid_reg;
        if (phase_reg == PH_TBL) begin
            phase_next = PH_MRK;
        end else if (rescan || scan_acc) begin
            phase_next = PH_TBL;
        end
        if (phase_reg == PH_MRK) begin
            cur_next = cur_fin;
            if (rescan) begin
                span_open_next  = open_d;
                span_first_next = first_d;
                span_last_next  = last_d;
                pend_valid_next = 1'b1;
            end else begin
                pend_valid_next = 1'b0;
                if (eot_reg) begin
                    span_open_next  = 1'b0;
                    span_first_next = '0;
                    span_last_next  = '0;
                    pos_next        = '0;
                end else begin
                    span_open_next  = open_d;
                    span_first_next = first_d;
                    span_last_next  = last_d;
                    pos_next        = PB'(pos_reg + PB'(1));
                end
            end
        end
        if (cfg_wr_en && cfg_index == dms_pkg::CFG_START_STATE) begin
            cur_next = dms_pkg::state_num(cfg_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            mode_reg        <= dms_pkg::MODE_FIND_ALL;
            start_state_reg <= '0;
            cur_reg         <= '0;
            span_open_reg   <= 1'b0;
            span_first_reg  <= '0;
            span_last_reg   <= '0;
            pos_reg         <= '0;
            pend_valid_reg  <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            cur_reg         <= cur_next;
            span_open_reg   <= span_open_next;
            span_first_reg  <= span_first_next;
            span_last_reg   <= span_last_next;
            pos_reg         <= pos_next;
            pend_valid_reg  <= pend_valid_next;
            if (cfg_wr_en && cfg_index == dms_pkg::CFG_MATCH_MODE) begin
                mode_reg <= cfg_data[0];
            end
            if (cfg_wr_en && cfg_index == dms_pkg::CFG_START_STATE) begin
                start_state_reg <= dms_pkg::state_num(cfg_data);
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        if (phase_reg == PH_TBL) begin
            ns_reg <= tbl_rdata;
        end
        if (scan_acc) begin
            col_reg <= col_in;
            eot_reg <= s_end_of_text;
        end
    end

`include "dfa_match_span_scanner_unit_assert.svh"

    `DMS_ASSERT_IMP(a_pend_in_flight, pend_valid_reg, phase_reg != PH_IDLE)
    `DMS_ASSERT_IMP(a_rescan_closed, (phase_reg == PH_TBL) && pend_valid_reg, !span_open_reg)
    `DMS_ASSERT_IMP(a_no_load_midscan, tbl_port.we || mark_port.we, phase_reg != PH_TBL)
    `DMS_ASSERT_NXT(a_rescan_reads, rescan, (phase_reg == PH_TBL) && pend_valid_reg)

endmodule
